@@ rtl/orl_pkg.sv @@
// Shared types, command and status codes for the ordered record list.
package orl_pkg;

  localparam int DEPTH_DEFAULT = 32;
  localparam int CW_DEFAULT    = $clog2(DEPTH_DEFAULT + 1);

  localparam logic [2:0] CMD_APPEND = 3'd0;
  localparam logic [2:0] CMD_INSERT = 3'd1;
  localparam logic [2:0] CMD_POP    = 3'd2;
  localparam logic [2:0] CMD_REMOVE = 3'd3;
  localparam logic [2:0] CMD_FIND   = 3'd4;
  localparam logic [2:0] CMD_COUNT  = 3'd5;

  localparam logic [2:0] STS_OK       = 3'd0;
  localparam logic [2:0] STS_FULL     = 3'd1;
  localparam logic [2:0] STS_EMPTY    = 3'd2;
  localparam logic [2:0] STS_BADPOS   = 3'd3;
  localparam logic [2:0] STS_NOTFOUND = 3'd4;

  typedef struct packed {
    logic [2:0]  cmd;
    logic [4:0]  position;
    logic        pop_last;
    logic [31:0] key_in;
    logic [63:0] payload_in;
  } in_item_t;

  typedef struct packed {
    logic [2:0]  status;
    logic [31:0] key_out;
    logic [63:0] payload_out;
    logic [4:0]  found_position;
    logic [5:0]  match_count;
    logic [5:0]  length;
  } out_item_t;

  typedef struct packed {
    logic [31:0] key;
    logic [63:0] payload;
  } rec_t;

  // What every cell does at the next edge.
  typedef enum logic [1:0] {
    CM_HOLD,
    CM_INSERT,
    CM_ROTATE,
    CM_DROP
  } cell_mode_t;

  typedef struct packed {
    cell_mode_t mode;
    rec_t       rec;
  } cell_ctl_t;

endpackage

@@ rtl/orl_cell.sv @@
// One list slot: holds a record and moves it to or from its neighbors.
module orl_cell #(
  parameter int IDX = 0,
  parameter int CW  = orl_pkg::CW_DEFAULT
) (
  input  logic              clk,
  input  orl_pkg::cell_ctl_t ctl,
  input  logic [CW-1:0]     pos,
  input  logic [CW-1:0]     len,
  input  orl_pkg::rec_t     prev_rec,
  input  orl_pkg::rec_t     next_rec,
  input  orl_pkg::rec_t     head_rec,
  output orl_pkg::rec_t     rec
);

  orl_pkg::rec_t rec_r;
  orl_pkg::rec_t rec_nxt;

  always_comb begin
    rec_nxt = rec_r;
    unique case (ctl.mode)
      orl_pkg::CM_INSERT: begin
        // open a gap at pos: slots above it take from below
        if (CW'(IDX) > pos) begin
          rec_nxt = prev_rec;
        end else if (CW'(IDX) == pos) begin
          rec_nxt = ctl.rec;
        end
      end
      orl_pkg::CM_ROTATE: begin
        // advance toward the head, the head record wraps to the tail
        if (CW'(IDX + 1) < len) begin
          rec_nxt = next_rec;
        end else if (CW'(IDX + 1) == len) begin
          rec_nxt = head_rec;
        end
      end
      orl_pkg::CM_DROP: begin
        rec_nxt = next_rec;
      end
      default: begin
        rec_nxt = rec_r;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    rec_r <= rec_nxt;
  end

  assign rec = rec_r;

endmodule

@@ rtl/orl_ctrl.sv @@
// Command sequencer: length, scan walk over the rotating chain, result register.
module orl_ctrl #(
  parameter int DEPTH = orl_pkg::DEPTH_DEFAULT,
  parameter int CW    = orl_pkg::CW_DEFAULT
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  orl_pkg::in_item_t   in_data,
  output logic                out_valid,
  input  logic                out_ready,
  output orl_pkg::out_item_t  out_data,
  input  orl_pkg::rec_t       head_rec,
  output orl_pkg::cell_ctl_t  cell_ctl,
  output logic [CW-1:0]       cell_pos,
  output logic [CW-1:0]       cell_len
);

  localparam int CMPW = (CW > 5) ? CW : 5;

  typedef enum logic {
    IDLE,
    SCAN
  } state_t;

  state_t             state_r, state_nxt;
  logic [CW-1:0]      count_r, count_nxt;
  orl_pkg::out_item_t out_r, out_nxt;
  logic               out_valid_r, out_valid_nxt;

  logic [2:0]         op_r, op_nxt;
  logic [31:0]        key_r, key_nxt;
  logic [63:0]        pay_r, pay_nxt;
  logic [CW-1:0]      tgt_r, tgt_nxt;
  logic [CW-1:0]      step_r, step_nxt;
  logic [CW-1:0]      total_r, total_nxt;
  logic [CW-1:0]      hits_r, hits_nxt;
  logic [CW-1:0]      first_r, first_nxt;
  logic               any_r, any_nxt;
  orl_pkg::rec_t      pop_r, pop_nxt;

  logic               accept;
  logic [CMPW-1:0]    pos_ext;
  logic [CMPW-1:0]    cnt_ext;
  logic               kmatch;
  logic               pmatch;
  logic               drop;
  logic               hit_inc;
  logic               start_scan;

  always_comb begin
    state_nxt     = state_r;
    count_nxt     = count_r;
    out_nxt       = out_r;
    out_valid_nxt = out_valid_r && !out_ready;
    op_nxt        = op_r;
    key_nxt       = key_r;
    pay_nxt       = pay_r;
    tgt_nxt       = tgt_r;
    step_nxt      = step_r;
    total_nxt     = total_r;
    hits_nxt      = hits_r;
    first_nxt     = first_r;
    any_nxt       = any_r;
    pop_nxt       = pop_r;
    cell_ctl.mode = orl_pkg::CM_HOLD;
    cell_ctl.rec  = '{key: in_data.key_in, payload: in_data.payload_in};
    cell_pos      = count_r;
    cell_len      = count_r;
    in_ready      = (state_r == IDLE) && (!out_valid_r || out_ready);
    accept        = in_valid && in_ready;
    pos_ext       = CMPW'(in_data.position);
    cnt_ext       = CMPW'(count_r);
    kmatch        = (head_rec.key == key_r);
    pmatch        = (head_rec.payload == pay_r);
    drop          = 1'b0;
    hit_inc       = 1'b0;
    start_scan    = 1'b0;

    unique case (state_r)
      IDLE: begin
        if (accept) begin
          out_nxt        = '0;
          out_nxt.status = orl_pkg::STS_OK;
          out_nxt.length = 6'(count_r);
          out_valid_nxt  = 1'b1;
          unique case (in_data.cmd) inside
            orl_pkg::CMD_APPEND, orl_pkg::CMD_INSERT: begin
              if (count_r == CW'(DEPTH)) begin
                out_nxt.status = orl_pkg::STS_FULL;
              end else if (in_data.cmd == orl_pkg::CMD_INSERT && pos_ext > cnt_ext) begin
                out_nxt.status = orl_pkg::STS_BADPOS;
              end else begin
                cell_ctl.mode  = orl_pkg::CM_INSERT;
                cell_pos       = (in_data.cmd == orl_pkg::CMD_APPEND) ? count_r :
                                 CW'(in_data.position);
                count_nxt      = count_r + CW'(1);
                out_nxt.length = 6'(count_nxt);
              end
            end
            orl_pkg::CMD_POP: begin
              if (count_r == '0) begin
                out_nxt.status = orl_pkg::STS_EMPTY;
              end else if (!in_data.pop_last && pos_ext >= cnt_ext) begin
                out_nxt.status = orl_pkg::STS_BADPOS;
              end else begin
                start_scan = 1'b1;
                tgt_nxt    = in_data.pop_last ? (count_r - CW'(1)) :
                             CW'(in_data.position);
              end
            end
            orl_pkg::CMD_REMOVE, orl_pkg::CMD_FIND: begin
              if (count_r == '0) begin
                out_nxt.status = orl_pkg::STS_NOTFOUND;
              end else begin
                start_scan = 1'b1;
              end
            end
            orl_pkg::CMD_COUNT: begin
              start_scan = (count_r != '0);
            end
            default: begin
              out_nxt.status = orl_pkg::STS_OK;
            end
          endcase
          if (start_scan) begin
            // hold the result back until the walk has seen every record
            out_valid_nxt = 1'b0;
            state_nxt     = SCAN;
            op_nxt        = in_data.cmd;
            key_nxt       = in_data.key_in;
            pay_nxt       = in_data.payload_in;
            step_nxt      = '0;
            total_nxt     = count_r;
            hits_nxt      = '0;
            first_nxt     = '0;
            any_nxt       = 1'b0;
          end
        end
      end
      SCAN: begin
        unique case (op_r)
          orl_pkg::CMD_POP:    drop = (step_r == tgt_r);
          orl_pkg::CMD_REMOVE: drop = kmatch && !any_r;
          default:             drop = 1'b0;
        endcase
        unique case (op_r) inside
          orl_pkg::CMD_REMOVE, orl_pkg::CMD_FIND: hit_inc = kmatch;
          orl_pkg::CMD_COUNT:                     hit_inc = pmatch;
          default:                                hit_inc = 1'b0;
        endcase
        cell_ctl.mode = drop ? orl_pkg::CM_DROP : orl_pkg::CM_ROTATE;
        hits_nxt      = hits_r + CW'(hit_inc);
        if (kmatch && !any_r) begin
          first_nxt = step_r;
        end
        any_nxt  = any_r || kmatch;
        step_nxt = step_r + CW'(1);
        if (drop) begin
          count_nxt = count_r - CW'(1);
          pop_nxt   = head_rec;
        end
        if (step_r == total_r - CW'(1)) begin
          state_nxt      = IDLE;
          out_valid_nxt  = 1'b1;
          out_nxt        = '0;
          out_nxt.status = orl_pkg::STS_OK;
          out_nxt.length = 6'(count_nxt);
          unique case (op_r) inside
            orl_pkg::CMD_POP: begin
              out_nxt.key_out     = pop_nxt.key;
              out_nxt.payload_out = pop_nxt.payload;
            end
            orl_pkg::CMD_REMOVE, orl_pkg::CMD_FIND: begin
              if (any_nxt) begin
                out_nxt.found_position = 5'(first_nxt);
                out_nxt.match_count    = 6'(hits_nxt);
              end else begin
                out_nxt.status = orl_pkg::STS_NOTFOUND;
              end
            end
            default: begin
              out_nxt.match_count = 6'(hits_nxt);
            end
          endcase
        end
      end
      default: begin
        state_nxt = IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= IDLE;
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      out_valid_r <= out_valid_nxt;
      out_r       <= out_nxt;
    end
  end

  always_ff @(posedge clk) begin
    op_r    <= op_nxt;
    key_r   <= key_nxt;
    pay_r   <= pay_nxt;
    tgt_r   <= tgt_nxt;
    step_r  <= step_nxt;
    total_r <= total_nxt;
    hits_r  <= hits_nxt;
    first_r <= first_nxt;
    any_r   <= any_nxt;
    pop_r   <= pop_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CW'(DEPTH))
    else $error("record count above depth");

  a_scan_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == SCAN |-> count_r != '0)
    else $error("walk running over an empty list");

  a_scan_out_free: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == SCAN |-> !out_valid_r)
    else $error("result register busy during a walk");

  a_scan_step: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == SCAN |-> step_r < total_r)
    else $error("walk ran past the list");

  a_hits_any: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == SCAN && (op_r == orl_pkg::CMD_FIND || op_r == orl_pkg::CMD_REMOVE)
      |-> any_r == (hits_r != '0))
    else $error("match count and first-match flag disagree");

endmodule

@@ rtl/ordered_record_list.sv @@
// Ordered record list: a chain of record cells driven by one command sequencer.
// The list holds up to DEPTH records of a 32-bit key and a 64-bit payload in a
// chain of cells. Append and insert shift the chain up at the edge that takes
// the request, and their result is registered at that same edge. Pop, remove,
// find and count-payload walk the list: the chain rotates one record past the
// head compare each cycle, dropping the selected record on the way, so the
// result is registered once the walk has passed every record (at once when
// the list is empty or the request is rejected). A new request is taken
// when the sequencer is idle and the result register is empty or being read in
// the same cycle. Every result reports the list length after the command.
module ordered_record_list #(
  parameter int DEPTH = orl_pkg::DEPTH_DEFAULT
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  orl_pkg::in_item_t  in_data,
  output logic               out_valid,
  input  logic               out_ready,
  output orl_pkg::out_item_t out_data
);

  localparam int CW = $clog2(DEPTH + 1);

  orl_pkg::cell_ctl_t cell_ctl;
  logic [CW-1:0]      cell_pos;
  logic [CW-1:0]      cell_len;
  orl_pkg::rec_t      rec_q    [DEPTH];
  orl_pkg::rec_t      prev_q   [DEPTH];
  orl_pkg::rec_t      next_q   [DEPTH];

  orl_ctrl #(
    .DEPTH (DEPTH),
    .CW    (CW)
  ) u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .head_rec  (rec_q[0]),
    .cell_ctl  (cell_ctl),
    .cell_pos  (cell_pos),
    .cell_len  (cell_len)
  );

  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    if (i == 0) begin : g_first
      assign prev_q[i] = cell_ctl.rec;
    end else begin : g_mid_prev
      assign prev_q[i] = rec_q[i-1];
    end
    if (i == DEPTH - 1) begin : g_last
      assign next_q[i] = rec_q[i];
    end else begin : g_mid_next
      assign next_q[i] = rec_q[i+1];
    end

    orl_cell #(
      .IDX (i),
      .CW  (CW)
    ) u_cell (
      .clk      (clk),
      .ctl      (cell_ctl),
      .pos      (cell_pos),
      .len      (cell_len),
      .prev_rec (prev_q[i]),
      .next_rec (next_q[i]),
      .head_rec (rec_q[0]),
      .rec      (rec_q[i])
    );
  end

endmodule

@@ tb/ordered_record_list_test.sv @@
// Self-checking testbench for the ordered record list: random stall handshakes, shadow list.
module ordered_record_list_test;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int LIST_DEPTH  = orl_pkg::DEPTH_DEFAULT;
  localparam int ITEM_TARGET = 1600;
  localparam int STALL_LIMIT = 2000;
  localparam int QUIET_TAIL  = 200;
  localparam int DRAIN_WAIT  = 2 * LIST_DEPTH + 8;

  // Command codes the block leaves unused.
  localparam logic [2:0] CMD_SPARE_A = 3'd6;
  localparam logic [2:0] CMD_SPARE_B = 3'd7;

  typedef struct packed {
    orl_pkg::rec_t [LIST_DEPTH-1:0] recs;
    logic [5:0]                     count;
  } list_t;

  logic               clk = 1'b0;
  logic               rst_n;
  logic               in_valid;
  logic               in_ready;
  orl_pkg::in_item_t  in_data;
  logic               out_valid;
  logic               out_ready;
  orl_pkg::out_item_t out_data;

  orl_pkg::in_item_t  requests_pending[$];
  orl_pkg::out_item_t results_due[$];
  list_t              planned_list;
  list_t              tracked_list;
  int                 failures;
  int                 in_hold_left;
  int                 out_hold_left;
  int                 stall_cycles;
  logic               in_took;

  ordered_record_list dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

  always #5 clk = ~clk;

  // Drop record at and shift the rest down by one.
  function automatic void drop_record(inout list_t lst, input int at);
    int i;
    for (i = at; i + 1 < int'(lst.count); i++) begin
      lst.recs[i] = lst.recs[i + 1];
    end
    lst.count = lst.count - 6'd1;
  endfunction

  // Apply one request to a list and return the result it produces.
  function automatic orl_pkg::out_item_t run_command(inout list_t lst,
                                                     input orl_pkg::in_item_t req);
    orl_pkg::out_item_t res;
    int                 pos;
    int                 i;
    int                 first;
    int                 hits;
    res   = '0;
    pos   = int'(req.position);
    first = 0;
    hits  = 0;
    case (req.cmd) inside
      orl_pkg::CMD_APPEND, orl_pkg::CMD_INSERT: begin
        if (req.cmd == orl_pkg::CMD_APPEND) pos = int'(lst.count);
        if (int'(lst.count) >= LIST_DEPTH) begin
          res.status = orl_pkg::STS_FULL;
        end else if (pos > int'(lst.count)) begin
          res.status = orl_pkg::STS_BADPOS;
        end else begin
          for (i = int'(lst.count); i > pos; i--) begin
            lst.recs[i] = lst.recs[i - 1];
          end
          lst.recs[pos].key     = req.key_in;
          lst.recs[pos].payload = req.payload_in;
          lst.count = lst.count + 6'd1;
        end
      end
      orl_pkg::CMD_POP: begin
        if (lst.count == 6'd0) begin
          res.status = orl_pkg::STS_EMPTY;
        end else begin
          if (req.pop_last) pos = int'(lst.count) - 1;
          if (pos >= int'(lst.count)) begin
            res.status = orl_pkg::STS_BADPOS;
          end else begin
            res.key_out     = lst.recs[pos].key;
            res.payload_out = lst.recs[pos].payload;
            drop_record(lst, pos);
          end
        end
      end
      orl_pkg::CMD_REMOVE, orl_pkg::CMD_FIND: begin
        for (i = 0; i < int'(lst.count); i++) begin
          if (lst.recs[i].key == req.key_in) begin
            if (hits == 0) first = i;
            hits++;
          end
        end
        if (hits == 0) begin
          res.status = orl_pkg::STS_NOTFOUND;
        end else begin
          res.found_position = first[4:0];
          res.match_count    = hits[5:0];
          if (req.cmd == orl_pkg::CMD_REMOVE) drop_record(lst, first);
        end
      end
      orl_pkg::CMD_COUNT: begin
        for (i = 0; i < int'(lst.count); i++) begin
          if (lst.recs[i].payload == req.payload_in) hits++;
        end
        res.match_count = hits[5:0];
      end
      default: ;
    endcase
    res.length = lst.count;
    return res;
  endfunction

  function automatic orl_pkg::in_item_t make_req(logic [2:0] cmd, logic [4:0] pos, logic last,
                                                 logic [31:0] key, logic [63:0] pay);
    orl_pkg::in_item_t req;
    req.cmd        = cmd;
    req.position   = pos;
    req.pop_last   = last;
    req.key_in     = key;
    req.payload_in = pay;
    return req;
  endfunction

  task automatic queue_request(input orl_pkg::in_item_t req);
    void'(run_command(planned_list, req));
    requests_pending.push_back(req);
  endtask

  task automatic flag_field(input string field, input logic [63:0] want,
                            input logic [63:0] got);
    if (want !== got) begin
      $display("%0t: %s mismatch, expected %0h, actual %0h", $time, field, want, got);
      failures++;
    end
  endtask

  // Drive requests at the falling edge; hold each one until it is taken.
  always @(negedge clk) begin
    if (rst_n) begin
      if (!in_valid || in_took) begin
        if (in_hold_left > 0) begin
          in_valid     <= 1'b0;
          in_hold_left <= in_hold_left - 1;
        end else if (requests_pending.size() == 0) begin
          in_valid <= 1'b0;
        end else if (requests_pending.size() >= QUIET_TAIL && $urandom_range(0, 7) == 0) begin
          in_valid     <= 1'b0;
          in_hold_left <= int'($urandom_range(0, 10));
        end else begin
          in_data  <= requests_pending.pop_front();
          in_valid <= 1'b1;
        end
      end
    end
  end

  always @(negedge clk) begin
    if (rst_n) begin
      if (out_hold_left > 0) begin
        out_ready     <= 1'b0;
        out_hold_left <= out_hold_left - 1;
      end else if (requests_pending.size() >= QUIET_TAIL && $urandom_range(0, 6) == 0) begin
        out_ready     <= 1'b0;
        out_hold_left <= int'($urandom_range(0, 10));
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  // Check results against the oldest expectation, then predict newly taken requests.
  always @(posedge clk) begin
    orl_pkg::out_item_t want;
    if (!rst_n) begin
      in_took <= 1'b0;
    end else begin
      in_took <= in_valid && in_ready;
      if (out_valid && out_ready) begin
        if (results_due.size() == 0) begin
          $display("%0t: unexpected result, expected none, actual %0h", $time, out_data);
          failures++;
        end else begin
          want = results_due.pop_front();
          flag_field("status", 64'(want.status), 64'(out_data.status));
          flag_field("key_out", 64'(want.key_out), 64'(out_data.key_out));
          flag_field("payload_out", want.payload_out, out_data.payload_out);
          flag_field("found_position", 64'(want.found_position),
                     64'(out_data.found_position));
          flag_field("match_count", 64'(want.match_count), 64'(out_data.match_count));
          flag_field("length", 64'(want.length), 64'(out_data.length));
        end
      end
      if (in_valid && in_ready) results_due.push_back(run_command(tracked_list, in_data));
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready)) begin
      stall_cycles <= 0;
    end else if (stall_cycles >= STALL_LIMIT) begin
      $display("FAIL ordered_record_list");
      $finish;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

  initial begin
    int          real_items;
    int          target_len;
    int          len;
    int          r;
    logic        growing;
    logic [2:0]  cmd;
    logic [4:0]  pos;
    logic        last;
    logic [31:0] key;
    logic [63:0] pay;

    rst_n         = 1'b0;
    in_valid      = 1'b0;
    in_data       = '0;
    out_ready     = 1'b0;
    failures      = 0;
    in_hold_left  = 0;
    out_hold_left = 0;
    stall_cycles  = 0;
    planned_list  = '0;
    tracked_list  = '0;

    // Directed: empty list, edges of position, duplicates, spare codes.
    queue_request(make_req(orl_pkg::CMD_POP, 5'd0, 1'b0, 32'd0, 64'd0));
    queue_request(make_req(orl_pkg::CMD_POP, 5'd0, 1'b1, 32'd0, 64'd0));
    queue_request(make_req(orl_pkg::CMD_REMOVE, 5'd0, 1'b0, 32'd5, 64'd0));
    queue_request(make_req(orl_pkg::CMD_FIND, 5'd0, 1'b0, 32'd5, 64'd0));
    queue_request(make_req(orl_pkg::CMD_COUNT, 5'd0, 1'b0, 32'd0, 64'd0));
    queue_request(make_req(orl_pkg::CMD_INSERT, 5'd1, 1'b0, 32'd1, 64'd1));
    queue_request(make_req(orl_pkg::CMD_INSERT, 5'd0, 1'b0, 32'd0, 64'd0));
    queue_request(make_req(orl_pkg::CMD_APPEND, 5'd31, 1'b1, 32'hFFFF_FFFF,
                           64'hFFFF_FFFF_FFFF_FFFF));
    queue_request(make_req(orl_pkg::CMD_INSERT, 5'd2, 1'b0, 32'd5, 64'd5));
    queue_request(make_req(orl_pkg::CMD_INSERT, 5'd1, 1'b0, 32'd5, 64'd0));
    queue_request(make_req(orl_pkg::CMD_FIND, 5'd0, 1'b0, 32'd5, 64'd0));
    queue_request(make_req(orl_pkg::CMD_FIND, 5'd0, 1'b0, 32'd7, 64'd0));
    queue_request(make_req(orl_pkg::CMD_COUNT, 5'd0, 1'b0, 32'd0, 64'd0));
    queue_request(make_req(orl_pkg::CMD_COUNT, 5'd0, 1'b0, 32'd0, 64'd123));
    queue_request(make_req(orl_pkg::CMD_REMOVE, 5'd0, 1'b0, 32'd5, 64'd0));
    queue_request(make_req(orl_pkg::CMD_REMOVE, 5'd0, 1'b0, 32'd9, 64'd0));
    queue_request(make_req(orl_pkg::CMD_POP, 5'd31, 1'b0, 32'd0, 64'd0));
    queue_request(make_req(orl_pkg::CMD_POP, 5'd3, 1'b0, 32'd0, 64'd0));
    queue_request(make_req(CMD_SPARE_A, 5'd3, 1'b1, 32'd5, 64'd5));
    queue_request(make_req(CMD_SPARE_B, 5'd31, 1'b1, 32'hFFFF_FFFF,
                           64'hFFFF_FFFF_FFFF_FFFF));
    queue_request(make_req(orl_pkg::CMD_POP, 5'd31, 1'b1, 32'd0, 64'd0));
    queue_request(make_req(orl_pkg::CMD_POP, 5'd0, 1'b0, 32'd0, 64'd0));
    queue_request(make_req(orl_pkg::CMD_POP, 5'd0, 1'b0, 32'd0, 64'd0));
    queue_request(make_req(orl_pkg::CMD_POP, 5'd0, 1'b1, 32'd0, 64'd0));
    real_items = requests_pending.size() - 2;

    // Random: walk the length between empty and full, lingering at both ends.
    target_len = LIST_DEPTH;
    while (real_items < ITEM_TARGET) begin
      len = int'(planned_list.count);
      if (len == target_len && $urandom_range(0, 3) == 0) begin
        r = int'($urandom_range(0, 3));
        target_len = (r == 0) ? 0 : (r == 1) ? LIST_DEPTH :
                     int'($urandom_range(0, LIST_DEPTH));
      end
      growing = (target_len > len) || (target_len == len && $urandom_range(0, 1) == 1);
      r = int'($urandom_range(0, 99));
      if (r < 2) begin
        cmd = r[0] ? CMD_SPARE_B : CMD_SPARE_A;
      end else if (growing) begin
        cmd = (r < 40) ? orl_pkg::CMD_APPEND : (r < 70) ? orl_pkg::CMD_INSERT :
              (r < 78) ? orl_pkg::CMD_POP : (r < 85) ? orl_pkg::CMD_REMOVE :
              (r < 93) ? orl_pkg::CMD_FIND : orl_pkg::CMD_COUNT;
      end else begin
        cmd = (r < 45) ? orl_pkg::CMD_POP : (r < 68) ? orl_pkg::CMD_REMOVE :
              (r < 80) ? orl_pkg::CMD_FIND : (r < 90) ? orl_pkg::CMD_COUNT :
              (r < 95) ? orl_pkg::CMD_APPEND : orl_pkg::CMD_INSERT;
      end

      pos  = 5'($urandom_range(0, 31));
      last = 1'($urandom_range(0, 1));
      if (cmd == orl_pkg::CMD_INSERT && $urandom_range(0, 7) != 0) begin
        pos = 5'($urandom_range(0, len));
      end else if (cmd == orl_pkg::CMD_POP) begin
        last = ($urandom_range(0, 2) == 0);
        if (len > 0 && $urandom_range(0, 7) != 0) pos = 5'($urandom_range(0, len - 1));
      end

      r = int'($urandom_range(0, 9));
      if (r < 5 && len > 0) key = planned_list.recs[$urandom_range(0, len - 1)].key;
      else if (r < 8) key = 32'($urandom_range(0, 7));
      else key = 32'($urandom());

      r = int'($urandom_range(0, 9));
      if (r < 4 && len > 0) pay = planned_list.recs[$urandom_range(0, len - 1)].payload;
      else if (r < 6) pay = 64'($urandom_range(0, 3));
      else if (r == 6) pay = 64'hFFFF_FFFF_FFFF_FFFF;
      else pay = {32'($urandom()), 32'($urandom())};

      queue_request(make_req(cmd, pos, last, key, pay));
      if (cmd != CMD_SPARE_A && cmd != CMD_SPARE_B) real_items++;
    end

    repeat (4) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    while (requests_pending.size() != 0 || in_valid || results_due.size() != 0) begin
      @(posedge clk);
    end
    repeat (DRAIN_WAIT) @(posedge clk);

    if (results_due.size() != 0) begin
      $display("%0t: %0d results never arrived", $time, results_due.size());
      failures++;
    end
    if (failures == 0) begin
      $display("PASS ordered_record_list");
    end else begin
      $display("FAIL ordered_record_list");
    end
    $finish;
  end

endmodule

@@ sim.f @@
rtl/orl_pkg.sv
rtl/orl_cell.sv
rtl/orl_ctrl.sv
rtl/ordered_record_list.sv
tb/ordered_record_list_test.sv
